// ----- design/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants of the vertex normal accumulator
// Field widths, command and status codes, controller states, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int VCOUNT_RESET     = 1024;

  localparam int CFG_BITS    = 11;
  localparam int IDX_BITS    = 10;
  localparam int COORD_BITS  = 16;
  localparam int POS_BITS    = 3 * COORD_BITS;
  localparam int IN_BITS     = 4 * IDX_BITS + POS_BITS;
  localparam int NORMAL_BITS = 16;
  localparam int OUT_BITS    = 3 * NORMAL_BITS;
  localparam int SUM_BITS    = 24;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int MAG_BITS   = CROSS_BITS;
  localparam int NORM_TOP   = 29;
  localparam int SQ_BITS    = 2 * (NORM_TOP + 1);
  localparam int SS_BITS    = SQ_BITS + 2;
  localparam int ROOT_BITS  = SS_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int QBITS      = NORMAL_FRAC_BITS + 3;
  localparam int NUM_BITS   = NORM_TOP + 1 + NORMAL_FRAC_BITS + 1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] RS_OK     = 2'd0;
  localparam logic [1:0] RS_BAD    = 2'd1;
  localparam logic [1:0] RS_UNUSED = 2'd2;

  localparam logic [1:0] FLAG_WRITTEN = 2'b01;
  localparam logic [1:0] FLAG_USED    = 2'b10;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_WRITE, ST_C_ADDR, ST_C_CAP, ST_C_DONE,
    ST_MUL, ST_SUB, ST_LOAD, ST_NORM, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT,
    ST_DIV_INIT, ST_DIV_STEP, ST_DIV_STORE, ST_A_ADDR, ST_A_WR,
    ST_R_ADDR, ST_R_CAP, ST_OUT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_VWRITE, OP_C_ADDR, OP_C_CAP, OP_DIFF,
    OP_MUL, OP_SUB, OP_LOAD, OP_NORM, OP_ZMARK, OP_SQ_MUL, OP_SQ_ACC,
    OP_SQRT, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE, OP_A_ADDR, OP_A_WR,
    OP_R_ADDR, OP_R_CAP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   j_clr;
    logic   step_clr;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clear_last;
    logic       j_last;
    logic       tri_bad;
    logic       is_zero;
    logic       is_norm;
    logic       sqrt_last;
    logic       div_last;
    logic       rd_go;
    logic       out_busy;
  } stat_t;

endpackage

// ----- design/vna_controller.sv -----
// ----------------------------------------------------------------------------
// vna_controller: sequencing state machine
// Steps the datapath through write, triangle and read commands.
// ----------------------------------------------------------------------------
module vna_controller import vna_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (stat.cmd)
          CMD_WRITE: state_next = ST_WRITE;
          CMD_TRI:   state_next = ST_C_ADDR;
          CMD_READ:  state_next = ST_R_ADDR;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_WRITE:    state_next = ST_IDLE;
      ST_C_ADDR:   state_next = ST_C_CAP;
      ST_C_CAP:    state_next = stat.j_last ? ST_C_DONE : ST_C_ADDR;
      ST_C_DONE:   state_next = stat.tri_bad ? ST_IDLE : ST_MUL;
      ST_MUL:      state_next = ST_SUB;
      ST_SUB:      state_next = stat.j_last ? ST_LOAD : ST_MUL;
      ST_LOAD:     state_next = ST_NORM;
      ST_R_ADDR:   state_next = ST_R_CAP;
      ST_R_CAP:    state_next = stat.rd_go ? ST_NORM : ST_OUT;
      ST_NORM: begin
        if (stat.is_zero) begin
          state_next = (stat.cmd == CMD_READ) ? ST_OUT : ST_IDLE;
        end else if (stat.is_norm) begin
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL:   state_next = ST_SQ_ACC;
      ST_SQ_ACC:   state_next = stat.j_last ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT:     if (stat.sqrt_last) state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (stat.div_last) state_next = ST_DIV_STORE;
      ST_DIV_STORE: begin
        if (!stat.j_last) begin
          state_next = ST_DIV_INIT;
        end else begin
          state_next = (stat.cmd == CMD_TRI) ? ST_A_ADDR : ST_OUT;
        end
      end
      ST_A_ADDR:   state_next = ST_A_WR;
      ST_A_WR:     state_next = stat.j_last ? ST_IDLE : ST_A_ADDR;
      ST_OUT:      if (!stat.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    ctrl = '{op: OP_NONE, j_clr: 1'b0, step_clr: 1'b0};
    case (state)
      ST_CLEAR:    ctrl.op = OP_CLEAR;
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.op = OP_LATCH;
          ctrl.j_clr = 1'b1;
        end
      end
      ST_WRITE:    ctrl.op = OP_VWRITE;
      ST_C_ADDR:   ctrl.op = OP_C_ADDR;
      ST_C_CAP: begin
        ctrl.op = OP_C_CAP;
        ctrl.j_clr = stat.j_last;
      end
      ST_C_DONE:   ctrl.op = OP_DIFF;
      ST_MUL:      ctrl.op = OP_MUL;
      ST_SUB: begin
        ctrl.op = OP_SUB;
        ctrl.j_clr = stat.j_last;
      end
      ST_LOAD:     ctrl.op = OP_LOAD;
      ST_R_ADDR:   ctrl.op = OP_R_ADDR;
      ST_R_CAP:    ctrl.op = OP_R_CAP;
      ST_NORM: begin
        if (stat.is_zero) begin
          ctrl.op = OP_ZMARK;
        end else if (stat.is_norm) begin
          ctrl.j_clr = 1'b1;
        end else begin
          ctrl.op = OP_NORM;
        end
      end
      ST_SQ_MUL:   ctrl.op = OP_SQ_MUL;
      ST_SQ_ACC: begin
        ctrl.op = OP_SQ_ACC;
        ctrl.j_clr = stat.j_last;
        ctrl.step_clr = stat.j_last;
      end
      ST_SQRT:     ctrl.op = OP_SQRT;
      ST_DIV_INIT: begin
        ctrl.op = OP_DIV_INIT;
        ctrl.step_clr = 1'b1;
      end
      ST_DIV_STEP: ctrl.op = OP_DIV_STEP;
      ST_DIV_STORE: begin
        ctrl.op = OP_DIV_STORE;
        ctrl.j_clr = stat.j_last;
      end
      ST_A_ADDR:   ctrl.op = OP_A_ADDR;
      ST_A_WR: begin
        ctrl.op = OP_A_WR;
        ctrl.j_clr = stat.j_last;
      end
      ST_OUT:      if (!stat.out_busy) ctrl.op = OP_OUT;
      default:     ctrl.op = OP_NONE;
    endcase
  end

endmodule

// ----- design/vna_datapath.sv -----
// ----------------------------------------------------------------------------
// vna_datapath: vertex stores, cross product and unit-length scaling
// Position, sum and flag memories; multipliers shared across the axes, square root and
// divider steps driven by the controller; output register.
// ----------------------------------------------------------------------------
module vna_datapath import vna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  output stat_t               stat,
  input  logic [IN_BITS-1:0]  s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [OUT_BITS-1:0] m_tdata,
  output logic [1:0]          m_tuser
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = ($clog2(MAX_VERTICES + 1) > 5) ? $clog2(MAX_VERTICES + 1) : 5;
  localparam int VC_RESET = (MAX_VERTICES < VCOUNT_RESET) ? MAX_VERTICES : VCOUNT_RESET;
  localparam logic signed [SUM_BITS:0] SAT_HI = (SUM_BITS + 1)'((1 << (SUM_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS:0] SAT_LO = -SAT_HI - 1;

  logic [POS_BITS-1:0]   pos_mem [MAX_VERTICES];
  logic [3*SUM_BITS-1:0] sum_mem [MAX_VERTICES];
  logic [1:0]            flag_mem [MAX_VERTICES];
  logic [POS_BITS-1:0]   pos_q;
  logic [3*SUM_BITS-1:0] sum_q;
  logic [1:0]            flag_q;

  logic [1:0]            cmd_r;
  logic [IDX_BITS-1:0]   vi;
  logic [IDX_BITS-1:0]   corner [3];
  logic [POS_BITS-1:0]   pos_in;
  logic [POS_BITS-1:0]   cpos [3];
  logic signed [DIFF_BITS-1:0]  d [6];
  logic signed [PROD_BITS-1:0]  p1, p2;
  logic signed [CROSS_BITS-1:0] cr [3];
  logic [MAG_BITS-1:0]   m [3];
  logic [2:0]            neg;
  logic [SQ_BITS-1:0]    sq_p;
  logic [SS_BITS-1:0]    ss;
  logic [REM_BITS-1:0]   srem;
  logic [ROOT_BITS-1:0]  root;
  logic [NUM_BITS-1:0]   dnum;
  logic [ROOT_BITS:0]    drem;
  logic [QBITS-1:0]      quo;
  logic signed [NORMAL_BITS-1:0] nrm [3];

  logic [1:0]            j;
  logic [CW-1:0]         step;
  logic                  tri_bad;
  logic [1:0]            rstat;
  logic [CFG_BITS-1:0]   vcount;

  logic [IDX_BITS-1:0]   corner_sel;
  logic [AW-1:0]         raddr, waddr;
  logic                  vi_ok, corner_ok;
  logic                  pos_we, sum_we, flag_we;
  logic [3*SUM_BITS-1:0] sum_wdata;
  logic [1:0]            flag_wdata;
  logic signed [DIFF_BITS-1:0] ma, mb, mc, md;
  logic [MAG_BITS-1:0]   orv;
  logic                  hi_bits;
  logic [NORM_TOP:0]     mj;
  logic [REM_BITS-1:0]   rem_in;
  logic [ROOT_BITS-1:0]  root_in;
  logic [REM_BITS+1:0]   rsh;
  logic [REM_BITS-1:0]   trial;
  logic [NUM_BITS-1:0]   num;
  logic [ROOT_BITS:0]    r2;
  logic [NORMAL_BITS-1:0] q16;

  function automatic logic [MAG_BITS-1:0] mag_cross(input logic signed [CROSS_BITS-1:0] v);
    logic [CROSS_BITS-1:0] u;
    u = v[CROSS_BITS-1] ? CROSS_BITS'(-v) : CROSS_BITS'(v);
    return MAG_BITS'(u);
  endfunction

  function automatic logic [MAG_BITS-1:0] mag_sum(input logic signed [SUM_BITS-1:0] v);
    logic [SUM_BITS-1:0] u;
    u = v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
    return MAG_BITS'(u);
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] a,
                                                  input logic signed [NORMAL_BITS-1:0] b);
    logic signed [SUM_BITS:0] s;
    s = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(b);
    if (s > SAT_HI) return SUM_BITS'(SAT_HI);
    if (s < SAT_LO) return SUM_BITS'(SAT_LO);
    return SUM_BITS'(s);
  endfunction

  always_comb begin
    case (j)
      2'd0:    corner_sel = corner[0];
      2'd1:    corner_sel = corner[1];
      default: corner_sel = corner[2];
    endcase
    case (j)
      2'd0:    mj = m[0][NORM_TOP:0];
      2'd1:    mj = m[1][NORM_TOP:0];
      default: mj = m[2][NORM_TOP:0];
    endcase
  end

  assign vi_ok     = CFG_BITS'(vi) < vcount;
  assign corner_ok = (CFG_BITS'(corner_sel) < vcount) && flag_q[0];

  always_comb begin
    case (ctrl.op)
      OP_C_ADDR, OP_A_ADDR: raddr = AW'(corner_sel);
      default:              raddr = AW'(vi);
    endcase
    case (ctrl.op)
      OP_CLEAR: waddr = step[AW-1:0];
      OP_A_WR:  waddr = AW'(corner_sel);
      default:  waddr = AW'(vi);
    endcase
  end

  assign pos_we  = (ctrl.op == OP_VWRITE) && vi_ok;
  assign sum_we  = pos_we || (ctrl.op == OP_A_WR);
  assign flag_we = sum_we || (ctrl.op == OP_CLEAR);

  always_comb begin
    if (ctrl.op == OP_A_WR) begin
      sum_wdata = {sat_add($signed(sum_q[3*SUM_BITS-1:2*SUM_BITS]), nrm[2]),
                   sat_add($signed(sum_q[2*SUM_BITS-1:SUM_BITS]), nrm[1]),
                   sat_add($signed(sum_q[SUM_BITS-1:0]), nrm[0])};
    end else begin
      sum_wdata = '0;
    end
    case (ctrl.op)
      OP_VWRITE: flag_wdata = FLAG_WRITTEN;
      OP_A_WR:   flag_wdata = FLAG_WRITTEN | FLAG_USED;
      default:   flag_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[waddr] <= pos_in;
    pos_q <= pos_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[waddr] <= sum_wdata;
    sum_q <= sum_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[waddr] <= flag_wdata;
    flag_q <= flag_mem[raddr];
  end

  always_comb begin
    case (j)
      2'd0: begin
        ma = d[1]; mb = d[5]; mc = d[2]; md = d[4];
      end
      2'd1: begin
        ma = d[2]; mb = d[3]; mc = d[0]; md = d[5];
      end
      default: begin
        ma = d[0]; mb = d[4]; mc = d[1]; md = d[3];
      end
    endcase
  end

  assign orv     = m[0] | m[1] | m[2];
  assign hi_bits = |orv[MAG_BITS-1:NORM_TOP+1];

  assign rem_in  = (step == '0) ? '0 : srem;
  assign root_in = (step == '0) ? '0 : root;
  assign rsh     = {rem_in, ss[SS_BITS-1 -: 2]};
  assign trial   = {root_in[ROOT_BITS-2:0], 2'b01};
  assign num     = NUM_BITS'({mj, NORMAL_FRAC_BITS'(0)}) + NUM_BITS'(root >> 1);
  assign r2      = {drem[ROOT_BITS-1:0], dnum[QBITS-1]};
  assign q16     = NORMAL_BITS'(quo);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        cmd_r     <= s_tuser;
        vi        <= s_tdata[IDX_BITS-1:0];
        corner[0] <= s_tdata[2*IDX_BITS-1:IDX_BITS];
        corner[1] <= s_tdata[3*IDX_BITS-1:2*IDX_BITS];
        corner[2] <= s_tdata[4*IDX_BITS-1:3*IDX_BITS];
        pos_in    <= s_tdata[4*IDX_BITS +: POS_BITS];
      end
      OP_C_CAP: cpos[j] <= pos_q;
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d[i]   <= DIFF_BITS'($signed(cpos[1][i*COORD_BITS +: COORD_BITS]))
                  - DIFF_BITS'($signed(cpos[0][i*COORD_BITS +: COORD_BITS]));
          d[i+3] <= DIFF_BITS'($signed(cpos[2][i*COORD_BITS +: COORD_BITS]))
                  - DIFF_BITS'($signed(cpos[1][i*COORD_BITS +: COORD_BITS]));
        end
      end
      OP_MUL: begin
        p1 <= ma * mb;
        p2 <= mc * md;
      end
      OP_SUB: cr[j] <= CROSS_BITS'(p1) - CROSS_BITS'(p2);
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          m[i]   <= mag_cross(cr[i]);
          neg[i] <= cr[i][CROSS_BITS-1];
        end
      end
      OP_R_CAP: begin
        for (int i = 0; i < 3; i++) begin
          m[i]   <= mag_sum($signed(sum_q[i*SUM_BITS +: SUM_BITS]));
          neg[i] <= sum_q[(i+1)*SUM_BITS-1];
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          m[i] <= hi_bits ? (m[i] >> 1) : (m[i] << 1);
        end
      end
      OP_SQ_MUL: sq_p <= mj * mj;
      OP_SQ_ACC: ss <= ((j == 2'd0) ? '0 : ss) + SS_BITS'(sq_p);
      OP_SQRT: begin
        ss <= ss << 2;
        if (rsh >= (REM_BITS + 2)'(trial)) begin
          srem <= REM_BITS'(rsh - (REM_BITS + 2)'(trial));
          root <= {root_in[ROOT_BITS-2:0], 1'b1};
        end else begin
          srem <= rsh[REM_BITS-1:0];
          root <= {root_in[ROOT_BITS-2:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        dnum <= num;
        drem <= (ROOT_BITS + 1)'(num >> QBITS);
      end
      OP_DIV_STEP: begin
        dnum <= dnum << 1;
        if (r2 >= {1'b0, root}) begin
          drem <= r2 - {1'b0, root};
          quo  <= {quo[QBITS-2:0], 1'b1};
        end else begin
          drem <= r2;
          quo  <= {quo[QBITS-2:0], 1'b0};
        end
      end
      OP_DIV_STORE: nrm[j] <= neg[j] ? -$signed(q16) : $signed(q16);
      OP_OUT: begin
        m_tdata <= (rstat == RS_OK) ? {nrm[2], nrm[1], nrm[0]} : '0;
        m_tuser <= rstat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j        <= '0;
      step     <= '0;
      tri_bad  <= 1'b0;
      rstat    <= RS_OK;
      vcount   <= CFG_BITS'(VC_RESET);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= (32'(cfg_data) > MAX_VERTICES) ? CFG_BITS'(MAX_VERTICES) : cfg_data;
      end
      if (ctrl.j_clr) begin
        j <= '0;
      end else if (ctrl.op == OP_C_CAP || ctrl.op == OP_SUB || ctrl.op == OP_SQ_ACC ||
                   ctrl.op == OP_DIV_STORE || ctrl.op == OP_A_WR) begin
        j <= j + 2'd1;
      end
      if (ctrl.step_clr) begin
        step <= '0;
      end else if (ctrl.op == OP_CLEAR || ctrl.op == OP_SQRT || ctrl.op == OP_DIV_STEP) begin
        step <= step + CW'(1);
      end
      case (ctrl.op)
        OP_LATCH: begin
          tri_bad <= 1'b0;
          rstat   <= RS_OK;
        end
        OP_C_CAP: if (!corner_ok) tri_bad <= 1'b1;
        OP_R_CAP: begin
          if (!(vi_ok && flag_q[0])) begin
            rstat <= RS_BAD;
          end else if (!flag_q[1]) begin
            rstat <= RS_UNUSED;
          end
        end
        OP_ZMARK: rstat <= RS_UNUSED;
        default: ;
      endcase
      if (ctrl.op == OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.clear_last = step == CW'(MAX_VERTICES - 1);
    stat.j_last     = j == 2'd2;
    stat.tri_bad    = tri_bad;
    stat.is_zero    = orv == '0;
    stat.is_norm    = orv[NORM_TOP] && !hi_bits;
    stat.sqrt_last  = step == CW'(ROOT_BITS - 1);
    stat.div_last   = step == CW'(QBITS - 1);
    stat.rd_go      = vi_ok && flag_q[0] && flag_q[1];
    stat.out_busy   = m_tvalid && !m_tready;
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_STEP |-> drem < {1'b0, root})
    else $error("divider remainder not below root");

  a_sq_norm: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_SQ_MUL |-> orv[NORM_TOP] && !hi_bits)
    else $error("squares taken before normalization");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_OUT |-> !(m_tvalid && !m_tready))
    else $error("output register overwritten");

  a_zero_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != RS_OK |-> m_tdata == '0)
    else $error("nonzero normal with failing status");

endmodule

// ----- design/vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// vertex_normal_accumulator: smooth vertex normals from a triangle mesh
// Stores vertex positions, accumulates unit face normals per vertex and
// returns normalized vertex normals with a status.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata vertex/corners/position, tuser cmd
// m_*      out  m_tvalid/m_tready    tdata normal x/y/z, tuser read_status
// cfg_*    in   cfg_valid/cfg_ready  cfg_data vertex_count
//
// Add triangle: its time is set by the normalizing shift of up to 29 bits, one
// bit per cycle, the 31-step square root and three divisions; a bad corner or
// a degenerate triangle ends before the normalizing shift. Read: runs on the
// same unit and waits out any output stall; a bad or unused slot skips the
// arithmetic. After reset a clearing pass sweeps every entry of the flag
// memory; no item is accepted during it. A stalled result holds in the output
// register; a new item is accepted meanwhile.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // vertex_index, corner_a, corner_b, corner_c,
                                         // pos_x, pos_y, pos_z
  input  logic [1:0]          s_tuser,   // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata,   // normal_x, normal_y, normal_z
  output logic [1:0]          m_tuser,   // read_status
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  vna_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  vna_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- dv/tb_vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_normal_accumulator: self-checking bench of the normal accumulator
// Drives write-vertex, add-triangle and read items through the input stream,
// predicts each read's normal and status, and compares them with the output
// stream under random bursts, receiver stalls and several vertex counts.
// ----------------------------------------------------------------------------
module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam longint SUM_HI = (64'sd1 <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  vi, ca, cb, cc;
    logic [15:0] x, y, z;
  } mesh_item_t;

  typedef struct {
    logic [15:0] nx, ny, nz;
    logic [1:0]  status;
  } normal_rsp_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;   // vertex_index, corner_a, corner_b, corner_c,
                                       // pos_x, pos_y, pos_z
  logic [1:0]          s_tuser = '0;   // cmd
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;        // normal_x, normal_y, normal_z
  logic [1:0]          m_tuser;        // read_status
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  vertex_normal_accumulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic signed [15:0] pos_x_mem [MAX_VERTICES_DEF];
  logic signed [15:0] pos_y_mem [MAX_VERTICES_DEF];
  logic signed [15:0] pos_z_mem [MAX_VERTICES_DEF];
  longint             nsum_x [MAX_VERTICES_DEF];
  longint             nsum_y [MAX_VERTICES_DEF];
  longint             nsum_z [MAX_VERTICES_DEF];
  logic [1:0]         vflags [MAX_VERTICES_DEF];
  int                 vcount = VCOUNT_RESET;

  mesh_item_t  pending_items [$];
  normal_rsp_t expected_normals [$];
  int          fail_count = 0;
  int          accepted_count = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_scale(input longint vx, vy, vz,
                                    output longint nx, ny, nz);
    longint          v [3];
    longint          n [3];
    longint unsigned m [3];
    longint unsigned big, s, r, q;
    int              top;
    v[0] = vx; v[1] = vy; v[2] = vz;
    big = 0; s = 0; top = 0;
    nx = 0; ny = 0; nz = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) return 1'b0;
    while (top < 63 && (big >> (top + 1)) != 0) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > NORM_TOP) m[i] >>= (top - NORM_TOP);
      else m[i] <<= (NORM_TOP - top);
      s += m[i] * m[i];
    end
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << NORMAL_FRAC_BITS) + (r >> 1)) / r;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    nx = n[0]; ny = n[1]; nz = n[2];
    return 1'b1;
  endfunction

  function automatic longint clamp_add(input longint a, b);
    longint s;
    s = a + b;
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  function automatic bit slot_valid(input int idx);
    return idx < vcount && vflags[idx][0];
  endfunction

  task automatic accumulate_item(input mesh_item_t it);
    longint      d [6];
    longint      fx, fy, fz;
    int          k [3];
    normal_rsp_t rsp;
    case (it.cmd)
      CMD_WRITE: begin
        if (it.vi < vcount) begin
          pos_x_mem[it.vi] = it.x;
          pos_y_mem[it.vi] = it.y;
          pos_z_mem[it.vi] = it.z;
          nsum_x[it.vi] = 0; nsum_y[it.vi] = 0; nsum_z[it.vi] = 0;
          vflags[it.vi] = FLAG_WRITTEN;
        end
      end
      CMD_TRI: begin
        k[0] = int'(it.ca); k[1] = int'(it.cb); k[2] = int'(it.cc);
        if (slot_valid(k[0]) && slot_valid(k[1]) && slot_valid(k[2])) begin
          d[0] = longint'(pos_x_mem[k[1]]) - longint'(pos_x_mem[k[0]]);
          d[1] = longint'(pos_y_mem[k[1]]) - longint'(pos_y_mem[k[0]]);
          d[2] = longint'(pos_z_mem[k[1]]) - longint'(pos_z_mem[k[0]]);
          d[3] = longint'(pos_x_mem[k[2]]) - longint'(pos_x_mem[k[1]]);
          d[4] = longint'(pos_y_mem[k[2]]) - longint'(pos_y_mem[k[1]]);
          d[5] = longint'(pos_z_mem[k[2]]) - longint'(pos_z_mem[k[1]]);
          if (unit_scale(d[1] * d[5] - d[2] * d[4], d[2] * d[3] - d[0] * d[5],
                         d[0] * d[4] - d[1] * d[3], fx, fy, fz)) begin
            for (int i = 0; i < 3; i++) begin
              nsum_x[k[i]] = clamp_add(nsum_x[k[i]], fx);
              nsum_y[k[i]] = clamp_add(nsum_y[k[i]], fy);
              nsum_z[k[i]] = clamp_add(nsum_z[k[i]], fz);
              vflags[k[i]] |= FLAG_USED;
            end
          end
        end
      end
      CMD_READ: begin
        fx = 0; fy = 0; fz = 0;
        if (!slot_valid(int'(it.vi))) rsp.status = RS_BAD;
        else if (!vflags[it.vi][1]) rsp.status = RS_UNUSED;
        else if (unit_scale(nsum_x[it.vi], nsum_y[it.vi], nsum_z[it.vi], fx, fy, fz))
          rsp.status = RS_OK;
        else rsp.status = RS_UNUSED;
        rsp.nx = fx[15:0]; rsp.ny = fy[15:0]; rsp.nz = fz[15:0];
        expected_normals.push_back(rsp);
      end
      default: ;
    endcase
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_item(pending_items.pop_front());
        accepted_count++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_items[0].cmd;
          s_tdata  <= {pending_items[0].z, pending_items[0].y, pending_items[0].x,
                       pending_items[0].cc, pending_items[0].cb, pending_items[0].ca,
                       pending_items[0].vi};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int  rdy_cycle = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    rdy_cycle++;
    if (!hold_done && accepted_count >= 120) begin
      hold_done = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rdy_cycle[7]) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_rsp_t exp_rsp;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected result item: tdata=%h tuser=%0d", m_tdata, m_tuser);
        fail_count++;
      end else begin
        exp_rsp = expected_normals.pop_front();
        if (m_tdata[15:0] !== exp_rsp.nx) begin
          $error("normal_x: expected %0d actual %0d", $signed(exp_rsp.nx),
                 $signed(m_tdata[15:0]));
          fail_count++;
        end
        if (m_tdata[31:16] !== exp_rsp.ny) begin
          $error("normal_y: expected %0d actual %0d", $signed(exp_rsp.ny),
                 $signed(m_tdata[31:16]));
          fail_count++;
        end
        if (m_tdata[47:32] !== exp_rsp.nz) begin
          $error("normal_z: expected %0d actual %0d", $signed(exp_rsp.nz),
                 $signed(m_tdata[47:32]));
          fail_count++;
        end
        if (m_tuser !== exp_rsp.status) begin
          $error("read_status: expected %0d actual %0d", exp_rsp.status, m_tuser);
          fail_count++;
        end
      end
    end
  end

  function automatic mesh_item_t noise_item();
    mesh_item_t it;
    it.cmd = 2'($urandom_range(0, 3));
    it.vi = 10'($urandom); it.ca = 10'($urandom); it.cb = 10'($urandom);
    it.cc = 10'($urandom);
    it.x = 16'($urandom); it.y = 16'($urandom); it.z = 16'($urandom);
    return it;
  endfunction

  function automatic mesh_item_t make_item(input logic [1:0] cmd, input int vi,
                                           input int ca, cb, cc, x, y, z);
    mesh_item_t it;
    it = noise_item();
    it.cmd = cmd;
    if (cmd == CMD_WRITE || cmd == CMD_READ) it.vi = 10'(vi);
    if (cmd == CMD_WRITE) begin
      it.x = 16'(x); it.y = 16'(y); it.z = 16'(z);
    end
    if (cmd == CMD_TRI) begin
      it.ca = 10'(ca); it.cb = 10'(cb); it.cc = 10'(cc);
    end
    return it;
  endfunction

  function automatic int pick_slot(input int pool);
    return ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, pool - 1);
  endfunction

  function automatic mesh_item_t random_item(input int pool);
    mesh_item_t it;
    int sel, a;
    it = noise_item();
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      it.cmd = CMD_WRITE;
      it.vi = 10'(pick_slot(pool));
      if ($urandom_range(0, 1)) begin
        it.x = 16'($urandom_range(0, 2047) - 1024);
        it.y = 16'($urandom_range(0, 2047) - 1024);
        it.z = 16'($urandom_range(0, 2047) - 1024);
      end
    end else if (sel < 65) begin
      it.cmd = CMD_TRI;
      a = pick_slot(pool);
      it.ca = 10'(a);
      it.cb = ($urandom_range(0, 9) == 0) ? 10'(a) : 10'(pick_slot(pool));
      it.cc = 10'(pick_slot(pool));
    end else if (sel < 95) begin
      it.cmd = CMD_READ;
      it.vi = 10'(pick_slot(pool));
    end else begin
      it.cmd = CMD_NONE;
    end
    return it;
  endfunction

  task automatic write_count(input int value);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vcount = value > MAX_VERTICES_DEF ? MAX_VERTICES_DEF : value;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_normals.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(input int count_value, input int n);
    int pool;
    write_count(count_value);
    pool = count_value < 10 ? count_value + 1 : 12;
    for (int i = 0; i < n; i++) pending_items.push_back(random_item(pool));
    drain();
  endtask

  initial begin
    for (int i = 0; i < MAX_VERTICES_DEF; i++) vflags[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_count(1024);
    pending_items.push_back(make_item(CMD_READ, 1023, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 1, 0, 0, 0, 256, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 2, 0, 0, 0, 0, 256, 0));
    pending_items.push_back(make_item(CMD_WRITE, 3, 0, 0, 0, 32767, 32767, 32767));
    pending_items.push_back(make_item(CMD_WRITE, 4, 0, 0, 0, -32768, -32768, -32768));
    pending_items.push_back(make_item(CMD_WRITE, 5, 0, 0, 0, 32767, -32768, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 0, 1, 2, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 0, 0, 1, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 0, 1, 9, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 3, 4, 5, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 3, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 5, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 0, 1, 2, 0, 0, 0));
    pending_items.push_back(make_item(CMD_TRI, 0, 2, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_WRITE, 1023, 0, 0, 0, -1, 1, -256));
    pending_items.push_back(make_item(CMD_READ, 1023, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_READ, 1, 0, 0, 0, 0, 0, 0));
    drain();

    // drive the sums of vertices 0, 1 and 2 into saturation
    for (int i = 0; i < 530; i++) begin
      pending_items.push_back(make_item(CMD_TRI, 0, 0, 1, 2, 0, 0, 0));
      if (i % 53 == 0) pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    end
    pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    drain();

    random_phase(1024, 250);
    random_phase(7, 150);
    random_phase(1, 60);
    random_phase(300, 150);
    random_phase(1024, 100);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/vna_pkg.sv
design/vna_controller.sv
design/vna_datapath.sv
design/vertex_normal_accumulator.sv
dv/tb_vertex_normal_accumulator.sv
